>>> design/erd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and word types of the expansion RAM DMA engine.
// No dependencies.
package erd_pkg;

  localparam int HOST_AW    = 16;  // host bus address width
  localparam int DATA_W     = 8;
  localparam int LEN_W      = 16;
  localparam int BANK_W     = 5;   // raw bank field and clipped bank count
  localparam int BANK_SHIFT = 16;  // 64 KiB banks
  localparam int CFG_W      = 5;   // widest config register
  localparam int CFG_IDX_W  = 1;

  localparam int MAX_BANKS_DEF = 16;

  localparam logic [CFG_W-1:0] NUM_BANKS_RST = 5'd16;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BANKS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_VEC = 1'd1;

  // item function
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_BYTE  = 1'b1;

  // transfer types
  localparam logic [1:0] TT_H2R  = 2'd0;
  localparam logic [1:0] TT_R2H  = 2'd1;
  localparam logic [1:0] TT_SWAP = 2'd2;
  localparam logic [1:0] TT_CMP  = 2'd3;

  // protected vector ranges
  localparam logic [HOST_AW-1:0] VEC_A_LO = 16'h031A;
  localparam logic [HOST_AW-1:0] VEC_A_HI = 16'h032D;
  localparam logic [HOST_AW-1:0] VEC_B_LO = 16'h0330;
  localparam logic [HOST_AW-1:0] VEC_B_HI = 16'h0333;

  typedef struct packed {
    logic              func;
    logic [1:0]        xfer_kind;
    logic              fix_host_addr;
    logic              fix_ram_addr;
    logic [HOST_AW-1:0] host_start;
    logic [15:0]       ram_start;
    logic [BANK_W-1:0] bank_raw;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] host_byte;
  } erd_in_t;

  typedef struct packed {
    logic [HOST_AW-1:0] write_addr;
    logic               host_write;
    logic [DATA_W-1:0]  write_data;
    logic [HOST_AW-1:0] next_read_addr;
    logic               end_of_block;
    logic               fault;
    logic               busy_res;
  } erd_out_t;

endpackage

>>> design/erd_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one word of type T.
// No dependencies; the word types come from erd_pkg at the instantiation.
interface erd_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/expansion_ram_dma_engine.sv
`timescale 1ns / 1ps
// Expansion RAM DMA engine: banked byte RAM, transfer sequencer, status.
// Depends on erd_pkg and erd_stream_if.

// After reset the engine sweeps the expansion RAM to zero, one byte per
// cycle, over all MAX_BANKS * 65536 bytes; in_ch.ready stays low until the
// sweep is done (config writes are taken throughout). One item is in work
// at a time and every item gives one result word. For a start word the bank
// is reduced modulo the bank count by a one-bit-per-cycle remainder unit
// (5 steps), then the last offset is checked against the memory present
// before the result is registered. A byte word during a transfer uses the
// registered RAM read at the cursor followed by the write-back; a byte word
// while idle answers with a status word in the next cycle.
// The next word is accepted only when the output register is free or
// is being drained in the same cycle. The host byte of each byte word
// must be the one read at next_read_addr of the previous result.
module expansion_ram_dma_engine
  import erd_pkg::*;
#(
  parameter int MAX_BANKS = MAX_BANKS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata,
  erd_stream_if.sink           in_ch,
  erd_stream_if.source         out_ch
);

  localparam int DEPTH  = MAX_BANKS * (2 ** BANK_SHIFT);
  localparam int RAM_AW = $clog2(DEPTH);
  localparam int CMP_W  = RAM_AW + 1;

  localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(DEPTH - 1);
  localparam logic [2:0]        MOD_LAST = 3'(BANK_W - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MOD   = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_BYTE  = 2'd3;

  // expansion RAM, one write and one registered read port
  logic [DATA_W-1:0] expansion_ram [DEPTH];
  logic [DATA_W-1:0] mem_rdata_r;
  logic              mem_we;
  logic [RAM_AW-1:0] mem_wa;
  logic [DATA_W-1:0] mem_wd;

  logic [1:0]         state_r, state_nxt;
  logic               clearing_r, clearing_nxt;
  logic [RAM_AW-1:0]  clr_cnt_r, clr_cnt_nxt;

  logic [CFG_W-1:0]   num_banks_r, num_banks_nxt;
  logic               ignore_vec_r, ignore_vec_nxt;

  logic [HOST_AW-1:0] host_cursor_r, host_cursor_nxt;
  logic [RAM_AW-1:0]  ram_cursor_r, ram_cursor_nxt;
  logic [LEN_W:0]     bytes_left_r, bytes_left_nxt;
  logic [1:0]         active_type_r, active_type_nxt;
  logic               fix_host_r, fix_host_nxt;
  logic               fix_ram_r, fix_ram_nxt;
  logic               end_r, end_nxt;
  logic               fault_r, fault_nxt;

  // start snapshot and remainder unit
  logic [15:0]        ram_start_r, ram_start_nxt;
  logic [LEN_W:0]     len_r, len_nxt;
  logic [LEN_W:0]     off_last_r, off_last_nxt;
  logic [BANK_W-1:0]  bank_sh_r, bank_sh_nxt;
  logic [BANK_W-1:0]  mod_rem_r, mod_rem_nxt;
  logic [2:0]         mod_cnt_r, mod_cnt_nxt;

  logic [DATA_W-1:0]  hbyte_r, hbyte_nxt;

  logic               out_valid_r, out_valid_nxt;
  erd_out_t           out_r, out_nxt;

  logic               in_acc;
  logic [BANK_W-1:0]  banks;
  logic [BANK_W:0]    trial;
  logic [CMP_W-1:0]   last_off;
  logic [CMP_W-1:0]   total;
  logic               oob;
  logic               vec_prot;

  assign in_ch.ready  = (state_r == S_IDLE) && !clearing_r && (!out_valid_r || out_ch.ready);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  // bank count clipped to what is built
  assign banks = ({1'b0, num_banks_r} > (BANK_W + 1)'(MAX_BANKS)) ? BANK_W'(MAX_BANKS)
                                                                 : num_banks_r;

  // one restoring remainder step
  assign trial = {mod_rem_r, bank_sh_r[BANK_W-1]};

  // last expansion offset touched vs. memory present
  assign last_off = CMP_W'({mod_rem_r, 16'h0000}) + CMP_W'(off_last_r);
  assign total    = CMP_W'({banks, 16'h0000});
  assign oob      = (banks == '0) || (last_off >= total);

  assign vec_prot = ignore_vec_r &&
                    (((host_cursor_r >= VEC_A_LO) && (host_cursor_r <= VEC_A_HI)) ||
                     ((host_cursor_r >= VEC_B_LO) && (host_cursor_r <= VEC_B_HI)));

  always_comb begin
    state_nxt       = state_r;
    clearing_nxt    = clearing_r;
    clr_cnt_nxt     = clr_cnt_r;
    num_banks_nxt   = num_banks_r;
    ignore_vec_nxt  = ignore_vec_r;
    host_cursor_nxt = host_cursor_r;
    ram_cursor_nxt  = ram_cursor_r;
    bytes_left_nxt  = bytes_left_r;
    active_type_nxt = active_type_r;
    fix_host_nxt    = fix_host_r;
    fix_ram_nxt     = fix_ram_r;
    end_nxt         = end_r;
    fault_nxt       = fault_r;
    ram_start_nxt   = ram_start_r;
    len_nxt         = len_r;
    off_last_nxt    = off_last_r;
    bank_sh_nxt     = bank_sh_r;
    mod_rem_nxt     = mod_rem_r;
    mod_cnt_nxt     = mod_cnt_r;
    hbyte_nxt       = hbyte_r;
    out_valid_nxt   = out_valid_r;
    out_nxt         = out_r;
    mem_we          = 1'b0;
    mem_wa          = ram_cursor_r;
    mem_wd          = hbyte_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_idx)
        CFG_NUM_BANKS:  num_banks_nxt  = cfg_wdata;
        CFG_IGNORE_VEC: ignore_vec_nxt = cfg_wdata[0];
        default: ;
      endcase
    end

    // power-on sweep of the RAM
    if (clearing_r) begin
      mem_we      = 1'b1;
      mem_wa      = clr_cnt_r;
      mem_wd      = '0;
      clr_cnt_nxt = clr_cnt_r + RAM_AW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clearing_nxt = 1'b0;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.data.func == FUNC_START) begin
            active_type_nxt = in_ch.data.xfer_kind;
            fix_host_nxt    = in_ch.data.fix_host_addr;
            fix_ram_nxt     = in_ch.data.fix_ram_addr;
            host_cursor_nxt = in_ch.data.host_start;
            end_nxt         = 1'b0;
            fault_nxt       = 1'b0;
            ram_start_nxt   = in_ch.data.ram_start;
            len_nxt         = {in_ch.data.length == '0, in_ch.data.length};
            off_last_nxt    = in_ch.data.fix_ram_addr ?
                              {1'b0, in_ch.data.ram_start} :
                              {1'b0, in_ch.data.ram_start} +
                              {1'b0, in_ch.data.length - 16'd1};
            bank_sh_nxt     = in_ch.data.bank_raw;
            mod_rem_nxt     = '0;
            mod_cnt_nxt     = '0;
            state_nxt       = S_MOD;
          end else if (bytes_left_r == '0) begin
            // nothing to move: report status only
            out_valid_nxt          = 1'b1;
            out_nxt.write_addr     = '0;
            out_nxt.host_write     = 1'b0;
            out_nxt.write_data     = '0;
            out_nxt.next_read_addr = host_cursor_r;
            out_nxt.end_of_block   = end_r;
            out_nxt.fault          = fault_r;
            out_nxt.busy_res       = 1'b0;
          end else begin
            // RAM read at ram_cursor_r lands in mem_rdata_r this edge
            hbyte_nxt = in_ch.data.host_byte;
            state_nxt = S_BYTE;
          end
        end
      end

      S_MOD: begin
        mod_rem_nxt = (trial >= {1'b0, banks}) ? BANK_W'(trial - {1'b0, banks})
                                               : BANK_W'(trial);
        bank_sh_nxt = {bank_sh_r[BANK_W-2:0], 1'b0};
        mod_cnt_nxt = mod_cnt_r + 3'd1;
        if (mod_cnt_r == MOD_LAST) begin
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        ram_cursor_nxt = RAM_AW'({mod_rem_r, ram_start_r});
        if (oob) begin
          fault_nxt      = 1'b1;
          end_nxt        = 1'b1;
          bytes_left_nxt = '0;
        end else begin
          bytes_left_nxt = len_r;
        end
        out_valid_nxt          = 1'b1;
        out_nxt.write_addr     = '0;
        out_nxt.host_write     = 1'b0;
        out_nxt.write_data     = '0;
        out_nxt.next_read_addr = host_cursor_r;
        out_nxt.end_of_block   = oob;
        out_nxt.fault          = oob;
        out_nxt.busy_res       = !oob;
        state_nxt              = S_IDLE;
      end

      S_BYTE: begin
        out_nxt.host_write = 1'b0;
        out_nxt.write_data = '0;
        case (active_type_r)
          TT_H2R: begin
            mem_we = 1'b1;
          end
          TT_R2H: begin
            if (!vec_prot) begin
              out_nxt.host_write = 1'b1;
              out_nxt.write_data = mem_rdata_r;
            end
          end
          TT_SWAP: begin
            mem_we = 1'b1;
            if (!vec_prot) begin
              out_nxt.host_write = 1'b1;
              out_nxt.write_data = mem_rdata_r;
            end
          end
          TT_CMP: begin
            if (hbyte_r != mem_rdata_r) begin
              fault_nxt = 1'b1;
            end
          end
          default: ;
        endcase
        if (!fix_host_r) begin
          host_cursor_nxt = host_cursor_r + 16'd1;
        end
        if (!fix_ram_r) begin
          ram_cursor_nxt = ram_cursor_r + RAM_AW'(1);
        end
        bytes_left_nxt = bytes_left_r - 17'd1;
        if (bytes_left_r == 17'd1) begin
          end_nxt = 1'b1;
        end
        out_valid_nxt          = 1'b1;
        out_nxt.write_addr     = host_cursor_r;
        out_nxt.next_read_addr = host_cursor_nxt;
        out_nxt.end_of_block   = end_nxt;
        out_nxt.fault          = fault_nxt;
        out_nxt.busy_res       = (bytes_left_r != 17'd1);
        state_nxt              = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // RAM: clocked write, registered read at the current cursor
  always_ff @(posedge clk) begin
    if (mem_we) begin
      expansion_ram[mem_wa] <= mem_wd;
    end
    mem_rdata_r <= expansion_ram[ram_cursor_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      clearing_r    <= 1'b1;
      clr_cnt_r     <= '0;
      num_banks_r   <= NUM_BANKS_RST;
      ignore_vec_r  <= 1'b0;
      host_cursor_r <= '0;
      ram_cursor_r  <= '0;
      bytes_left_r  <= '0;
      active_type_r <= TT_H2R;
      fix_host_r    <= 1'b0;
      fix_ram_r     <= 1'b0;
      end_r         <= 1'b0;
      fault_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      mod_cnt_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      clearing_r    <= clearing_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      num_banks_r   <= num_banks_nxt;
      ignore_vec_r  <= ignore_vec_nxt;
      host_cursor_r <= host_cursor_nxt;
      ram_cursor_r  <= ram_cursor_nxt;
      bytes_left_r  <= bytes_left_nxt;
      active_type_r <= active_type_nxt;
      fix_host_r    <= fix_host_nxt;
      fix_ram_r     <= fix_ram_nxt;
      end_r         <= end_nxt;
      fault_r       <= fault_nxt;
      out_valid_r   <= out_valid_nxt;
      mod_cnt_r     <= mod_cnt_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    ram_start_r <= ram_start_nxt;
    len_r       <= len_nxt;
    off_last_r  <= off_last_nxt;
    bank_sh_r   <= bank_sh_nxt;
    mod_rem_r   <= mod_rem_nxt;
    hbyte_r     <= hbyte_nxt;
    out_r       <= out_nxt;
  end

  // no words taken while the RAM sweep runs
  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ch.ready)
    else $error("word accepted during RAM sweep");

  // a byte cycle is only run with bytes remaining
  a_byte_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BYTE) |-> (bytes_left_r != '0))
    else $error("byte cycle with no bytes left");

  // a start result is either running or ended, never both
  a_start_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |=> (out_valid_r && (out_r.busy_res != out_r.end_of_block)))
    else $error("start result status inconsistent");

  // end-of-block stays clear while bytes remain
  a_busy_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    (bytes_left_r != '0) |-> !end_r)
    else $error("end-of-block set during transfer");

endmodule
